// ===== design/binary_threshold_dilate_core_macros.svh =====
// Assertion macros shared by the checker of the threshold and dilation core.
`ifndef BINARY_THRESHOLD_DILATE_CORE_MACROS_SVH
`define BINARY_THRESHOLD_DILATE_CORE_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent.
`define BTD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btd check failed in the same cycle");

// The consequence must hold in the cycle after the antecedent.
`define BTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btd check failed in the following cycle");

`endif

// ===== design/btd_pkg.sv =====
// Types and constants shared by the threshold and dilation core and its checker.
package btd_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;
   localparam int DEFAULT_PASSES     = 2;

   localparam int DIM_W       = 11;
   localparam int THRESH_W    = 10;
   localparam int CHAN_W      = 8;
   localparam int COORD_W     = 10;
   localparam int SUM_W       = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   // Each line store keeps four rows, addressed by the low two bits of the row.
   localparam int RING    = 4;
   localparam int SLOT_W  = 2;
   localparam int MIN_DIM = 3;

   localparam logic [DIM_W-1:0]    RESET_IMAGE_WIDTH  = 11'd1024;
   localparam logic [DIM_W-1:0]    RESET_IMAGE_HEIGHT = 11'd1024;
   localparam logic [THRESH_W-1:0] RESET_THRESHOLD    = 10'd382;
   localparam logic [SUM_W-1:0]    FULL_DARKNESS      = 10'd765;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARKNESS_THRESHOLD = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic               mask;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic               frame_end;
   } rsp_payload_type;

endpackage

// ===== design/binary_threshold_dilate_core.sv =====
// Streaming darkness threshold followed by a chain of 4-neighbour binary dilations.
//
//   Channel | Direction | Handshake            | Transfer
//   --------+-----------+----------------------+--------------------------------------
//   req_    | in        | req_valid/req_stall  | one pixel (cmd 0) or drain tick (cmd 1)
//   rsp_    | out       | rsp_valid/rsp_stall  | one mask pixel with its column and row
//   csr_    | in        | csr_valid/csr_ready  | one register write (index, data)
//
// One item is taken per clock while req_stall is low; the single column memory is read
// one column ahead of the walker, so no pixel or drain tick has to wait for a memory read.
// A drain tick that must first step through rows lying above the first pending
// output (dilation deeper than the frame) holds req_stall for those extra columns.
// Reset is synchronous and clears position, handshake and register state only; the
// line memory is not cleared and needs no sweep, so the block is ready right after reset.
// A stalled rsp_ channel is absorbed by an output register plus one skid entry.
module binary_threshold_dilate_core #(
   parameter int MAX_WIDTH  = btd_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = btd_pkg::DEFAULT_MAX_HEIGHT,
   parameter int PASSES     = btd_pkg::DEFAULT_PASSES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  btd_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output btd_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [btd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [btd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import btd_pkg::*;

   // Column counter indexes the line memory; the row counter runs PASSES rows past
   // the frame height while the last rows are drained.
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + PASSES);
   localparam int CMP_W  = ((ROW_W > DIM_W) ? ROW_W : DIM_W) + 2;
   // One memory word per column: four ring rows for every stage whose values are
   // read back later (the threshold stage and every pass but the last).
   localparam int WORD_W = RING * ((PASSES > 0) ? PASSES : 1);

   // Configuration registers.
   logic [DIM_W-1:0]    image_width_ff;
   logic [DIM_W-1:0]    image_height_ff;
   logic [THRESH_W-1:0] threshold_ff;

   // Walker position and drain sequencing.
   logic [COL_W-1:0] in_column_ff, in_column_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic             loop_active_ff, loop_active_in;

   // Output register and skid entry.
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_data_ff, skid_data_in;

   // Line memory and its read side.
   logic [WORD_W-1:0] line_mem [MAX_WIDTH];
   logic [WORD_W-1:0] rd_mid_ff;
   logic [WORD_W-1:0] rd_right_ff;
   logic [WORD_W-1:0] left_ff;
   logic [WORD_W-1:0] new_word;
   logic [COL_W-1:0]  rd_mid_addr;
   logic [COL_W-1:0]  rd_right_addr;

   // Step datapath.
   logic [CMP_W-1:0]  w_x, h_x, x_x, row_x, out_r, row_inc;
   logic [SUM_W-1:0]  chan_sum, darkness;
   logic              fg;
   logic              accept, row_in_frame;
   logic              step_pixel, step_drain, step_fire;
   logic              has_result, produce, out_free;
   logic              col_edge, out_border, wrap, mask_value;
   logic [COL_W-1:0]  col_after;
   logic [ROW_W-1:0]  row_after, row_wrapped;
   rsp_payload_type   new_rsp;

   // The effective frame size is the programmed size clamped to the supported range.
   always_comb begin
      if (CMP_W'(image_width_ff) < CMP_W'(MIN_DIM)) begin
         w_x = CMP_W'(MIN_DIM);
      end else if (CMP_W'(image_width_ff) > CMP_W'(MAX_WIDTH)) begin
         w_x = CMP_W'(MAX_WIDTH);
      end else begin
         w_x = CMP_W'(image_width_ff);
      end
      if (CMP_W'(image_height_ff) < CMP_W'(MIN_DIM)) begin
         h_x = CMP_W'(MIN_DIM);
      end else if (CMP_W'(image_height_ff) > CMP_W'(MAX_HEIGHT)) begin
         h_x = CMP_W'(MAX_HEIGHT);
      end else begin
         h_x = CMP_W'(image_height_ff);
      end
   end

   assign x_x   = CMP_W'(in_column_ff);
   assign row_x = CMP_W'(in_row_ff);

   // Darkness is the distance of the channel sum from full white.
   assign chan_sum = SUM_W'(req_data.red) + SUM_W'(req_data.green) + SUM_W'(req_data.blue);
   assign darkness = FULL_DARKNESS - chan_sum;
   assign fg       = darkness > threshold_ff;

   // The input stalls while the skid entry is occupied or a drain tick is still
   // stepping through silent rows.
   assign req_stall = skid_valid_ff | loop_active_ff;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;

   // Pixels are taken only while the walker is inside the frame; drain ticks only
   // once it has passed the last input row. Anything else is dropped silently.
   assign row_in_frame = row_x < h_x;
   assign step_pixel   = accept && (req_data.cmd == CMD_PIXEL) && row_in_frame;
   assign step_drain   = (accept && (req_data.cmd == CMD_DRAIN) && !row_in_frame) ||
                         loop_active_ff;
   assign step_fire    = step_pixel || step_drain;

   assign col_edge = (x_x == '0) || ((x_x + CMP_W'(1)) >= w_x);

   // Dilation chain. Pass p works on row (row - p) at the walker's column. Its
   // neighbours from the previous stage come from the memory window (left, middle,
   // right words) except the one below, which that stage produces in this very step.
   always_comb begin : stage_chain
      logic              chain;
      logic              ok;
      logic              bord;
      logic              nb;
      logic [CMP_W-1:0]  r_x;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] prev_slot;
      logic [RING-1:0]   nib;

      new_word = rd_mid_ff;
      nib = new_word[RING-1:0];
      nib[in_row_ff[SLOT_W-1:0]] = fg;
      if (step_pixel) begin
         new_word[RING-1:0] = nib;
      end

      chain = fg;
      for (int p = 1; p <= PASSES; p++) begin
         r_x       = row_x - CMP_W'(p);
         ok        = (row_x >= CMP_W'(p)) && (r_x < h_x);
         bord      = col_edge || (r_x == '0) || ((r_x + CMP_W'(1)) >= h_x);
         slot      = in_row_ff[SLOT_W-1:0] - SLOT_W'(p);
         prev_slot = slot - SLOT_W'(1);

         nib = left_ff[(p-1)*RING +: RING];
         nb  = nib[slot];
         nib = rd_mid_ff[(p-1)*RING +: RING];
         nb  = nb | nib[slot] | nib[prev_slot];
         nib = rd_right_ff[(p-1)*RING +: RING];
         nb  = nb | nib[slot] | chain;

         chain = !bord && nb;

         // The last pass feeds the output directly and is never stored.
         if ((p < PASSES) && ok) begin
            nib = new_word[p*RING +: RING];
            nib[slot] = chain;
            new_word[p*RING +: RING] = nib;
         end
      end
      mask_value = chain && !out_border;
   end

   // The emitted pixel lags the walker by PASSES rows.
   assign out_r      = row_x - CMP_W'(PASSES);
   assign has_result = (row_x >= CMP_W'(PASSES)) && (out_r < h_x);
   assign out_border = col_edge || (out_r == '0) || ((out_r + CMP_W'(1)) >= h_x);

   always_comb begin
      new_rsp.mask      = mask_value;
      new_rsp.out_x     = COORD_W'(in_column_ff);
      new_rsp.out_y     = COORD_W'(out_r);
      new_rsp.frame_end = ((x_x + CMP_W'(1)) == w_x) && ((out_r + CMP_W'(1)) == h_x);
   end

   assign produce = step_fire && has_result;

   // Walker advance: next column, or wrap to the next row; the row counter wraps to
   // zero after the last drained row.
   assign wrap        = (x_x + CMP_W'(1)) >= w_x;
   assign row_inc     = row_x + CMP_W'(1);
   assign row_wrapped = (row_inc >= (h_x + CMP_W'(PASSES))) ? '0 : ROW_W'(row_inc);
   assign col_after   = wrap ? '0 : COL_W'(x_x + CMP_W'(1));
   assign row_after   = wrap ? row_wrapped : in_row_ff;

   assign in_column_in = step_fire ? col_after : in_column_ff;
   assign in_row_in    = step_fire ? row_after : in_row_ff;

   // A drain tick keeps stepping until it yields a pixel or the frame is done.
   assign loop_active_in = step_drain && !has_result && (row_after != '0);

   // The memory always presents the words of the next step's column and the one
   // to its right. The column being written is never one of them, since a frame
   // is at least three columns wide.
   assign rd_mid_addr   = reset ? '0 : in_column_in;
   assign rd_right_addr = COL_W'(rd_mid_addr + COL_W'(1));

   // Output register with one skid entry behind it; results leave in step order.
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = produce;
            skid_data_in  = new_rsp;
         end else begin
            out_valid_in = produce;
            out_data_in  = new_rsp;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_data_in  = new_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff    <= '0;
         in_row_ff       <= '0;
         loop_active_ff  <= 1'b0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
         image_width_ff  <= RESET_IMAGE_WIDTH;
         image_height_ff <= RESET_IMAGE_HEIGHT;
         threshold_ff    <= RESET_THRESHOLD;
      end else begin
         in_column_ff   <= in_column_in;
         in_row_ff      <= in_row_in;
         loop_active_ff <= loop_active_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  image_width_ff <= csr_data;
               end
               CSR_IMAGE_HEIGHT: begin
                  image_height_ff <= csr_data;
               end
               CSR_DARKNESS_THRESHOLD: begin
                  threshold_ff <= csr_data[THRESH_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers; the left word is the column just written back.
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
      if (step_fire) begin
         left_ff <= new_word;
      end
   end

   // Line memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (step_fire) begin
         line_mem[in_column_ff] <= new_word;
      end
      rd_mid_ff   <= line_mem[rd_mid_addr];
      rd_right_ff <= line_mem[rd_right_addr];
   end

endmodule

// ===== design/btd_checker.sv =====
// Port-level checker for the threshold and dilation core, with its bind statement.
`include "binary_threshold_dilate_core_macros.svh"

module btd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input btd_pkg::req_payload_type        req_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input btd_pkg::rsp_payload_type        rsp_data
);
   import btd_pkg::*;

   // Reset leaves no result pending and the input open.
   `BTD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall)

   // A result held against a stall keeps its contents.
   `BTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // The last pixel of a frame lies on the border and is always background.
   `BTD_ASSERT_SAME(a_frame_end_clear, clock, reset, rsp_valid && rsp_data.frame_end, !rsp_data.mask)

   // After a pixel transfer the input closes only when a result is waiting.
   `BTD_ASSERT_NEXT(a_pixel_open, clock, reset, req_valid && !req_stall && (req_data.cmd == CMD_PIXEL), !req_stall || rsp_valid)

endmodule

bind binary_threshold_dilate_core btd_checker u_btd_checker (.*);

// ===== verif/binary_threshold_dilate_core_tb.sv =====
// Self-checking testbench for the threshold and 4-neighbour dilation core.
module binary_threshold_dilate_core_tb;
   import btd_pkg::*;

   localparam int MAX_W            = DEFAULT_MAX_WIDTH;
   localparam int MAX_H            = DEFAULT_MAX_HEIGHT;
   localparam int PASSES           = DEFAULT_PASSES;
   localparam int RANDOM_ITEMS     = 900;
   localparam int WIDEST_FRAME     = 40;
   localparam int TALL_FRAME       = 64;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int REPORT_LIMIT     = 10;

   // Tracks the walker position, the line stores of every dilation stage and the
   // register values, and keeps the queue of mask pixels the block still owes us.
   class dilate_mask_tracker;
      // Left unknown on purpose: an unknown here shows up as a mismatch, which
      // would point at stimulus that reads a line entry never written.
      logic [MAX_W-1:0]    stage_rows [PASSES+1][RING];
      int unsigned         walk_col;
      int unsigned         walk_row;
      logic [DIM_W-1:0]    width_reg;
      logic [DIM_W-1:0]    height_reg;
      logic [THRESH_W-1:0] threshold_reg;
      rsp_payload_type     expected_pixels [$];
      int unsigned         error_count;

      function new();
         walk_col      = 0;
         walk_row      = 0;
         width_reg     = RESET_IMAGE_WIDTH;
         height_reg    = RESET_IMAGE_HEIGHT;
         threshold_reg = RESET_THRESHOLD;
         error_count   = 0;
      endfunction

      // Sizes outside the legal range are clamped, not rejected.
      function int unsigned frame_width();
         if (width_reg < MIN_DIM) return MIN_DIM;
         if (width_reg > MAX_W) return MAX_W;
         return width_reg;
      endfunction

      function int unsigned frame_height();
         if (height_reg < MIN_DIM) return MIN_DIM;
         if (height_reg > MAX_H) return MAX_H;
         return height_reg;
      endfunction

      // A column at or past width-1 counts as border, which matters after a
      // width change in the middle of a row.
      function bit on_border(int unsigned x, int unsigned r, int unsigned w, int unsigned h);
         return x == 0 || x >= w - 1 || r == 0 || r >= h - 1;
      endfunction

      function bit draining();
         return walk_row >= frame_height();
      endfunction

      function bit at_frame_start();
         return walk_row == 0 && walk_col == 0;
      endfunction

      function int unsigned outstanding();
         return expected_pixels.size();
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_IMAGE_WIDTH: begin
               width_reg = value;
            end
            CSR_IMAGE_HEIGHT: begin
               height_reg = value;
            end
            CSR_DARKNESS_THRESHOLD: begin
               threshold_reg = value[THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // One column step of the walker. Stage p holds row (walk_row - p); the last
      // stage's row is the one that leaves the block.
      function bit step_walker(bit has_pixel, logic fg, output rsp_payload_type pix);
         int unsigned w;
         int unsigned h;
         int unsigned x;
         int unsigned row;
         int unsigned r;
         logic        v;
         bit          produced;
         w        = frame_width();
         h        = frame_height();
         x        = walk_col;
         row      = walk_row;
         produced = 1'b0;
         pix      = '0;
         if (has_pixel) stage_rows[0][row % RING][x] = fg;
         for (int p = 1; p <= PASSES; p++) begin
            if (row < p) continue;
            r = row - p;
            if (r >= h) continue;
            v = 1'b0;
            if (!on_border(x, r, w, h)) begin
               v = stage_rows[p-1][r % RING][x] | stage_rows[p-1][r % RING][x-1] |
                   stage_rows[p-1][r % RING][x+1] | stage_rows[p-1][(r-1) % RING][x] |
                   stage_rows[p-1][(r+1) % RING][x];
            end
            stage_rows[p][r % RING][x] = v;
         end
         if (row >= PASSES && row - PASSES < h) begin
            r              = row - PASSES;
            pix.mask       = on_border(x, r, w, h) ? 1'b0 : stage_rows[PASSES][r % RING][x];
            pix.out_x      = COORD_W'(x);
            pix.out_y      = COORD_W'(r);
            pix.frame_end  = (x == w - 1) && (r == h - 1);
            produced       = 1'b1;
         end
         if (x + 1 >= w) begin
            walk_col = 0;
            walk_row = row + 1;
            if (walk_row >= h + PASSES) walk_row = 0;
         end else begin
            walk_col = x + 1;
         end
         return produced;
      endfunction

      function void take_request(req_payload_type item);
         rsp_payload_type pix;
         int unsigned     channel_sum;
         int unsigned     darkness;
         if (item.cmd == CMD_PIXEL) begin
            // Pixels that arrive while rows are still pending are dropped.
            if (draining()) return;
            channel_sum = item.red + item.green + item.blue;
            darkness    = FULL_DARKNESS - channel_sum;
            if (step_walker(1'b1, darkness > threshold_reg, pix)) expected_pixels.push_back(pix);
         end else begin
            // A drain before the frame's last pixel does nothing.
            if (!draining()) return;
            forever begin
               if (step_walker(1'b0, 1'b0, pix)) begin
                  expected_pixels.push_back(pix);
                  return;
               end
               if (walk_row == 0) return;
            end
         end
      endfunction

      function void take_mask_pixel(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_pixels.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected mask pixel: mask=%0d x=%0d y=%0d end=%0d",
                        got.mask, got.out_x, got.out_y, got.frame_end);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.mask !== want.mask || got.out_x !== want.out_x ||
             got.out_y !== want.out_y || got.frame_end !== want.frame_end) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("mask pixel mismatch: expected mask=%0d x=%0d y=%0d end=%0d, got mask=%0d x=%0d y=%0d end=%0d",
                        want.mask, want.out_x, want.out_y, want.frame_end,
                        got.mask, got.out_x, got.out_y, got.frame_end);
         end
      endfunction

      function void count_leftovers();
         if (expected_pixels.size() != 0) begin
            error_count += expected_pixels.size();
            $display("%0d expected mask pixels never arrived", expected_pixels.size());
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   dilate_mask_tracker tracker;
   int unsigned        burst_left;
   int unsigned        counted_items;
   bit                 long_hold_armed;

   binary_threshold_dilate_core #(
      .MAX_WIDTH (MAX_W),
      .MAX_HEIGHT(MAX_H),
      .PASSES    (PASSES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Offers one item and returns at the edge where its transfer happens. The
   // sender works in bursts; between bursts valid may drop for a random gap. Valid is
   // left high after a transfer so that back-to-back items never see it toggle
   // twice in one time step.
   task automatic send_item(input req_payload_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.take_request(item);
   endtask

   // Stops offering items, waits for every owed mask pixel and for any silent
   // drain steps still running, then lets the block settle.
   task automatic wait_for_drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value, input bit last);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      tracker.write_register(index, value);
      if (last) csr_valid <= 1'b0;
   endtask

   // Writes the chosen registers back to back; valid drops after the last one.
   task automatic program_sizes(input bit set_width, input logic [CSR_DATA_W-1:0] width_value,
                                input bit set_height, input logic [CSR_DATA_W-1:0] height_value,
                                input bit set_thresh, input logic [CSR_DATA_W-1:0] thresh_value);
      if (set_width) write_csr(CSR_IMAGE_WIDTH, width_value, !(set_height || set_thresh));
      if (set_height) write_csr(CSR_IMAGE_HEIGHT, height_value, !set_thresh);
      if (set_thresh) write_csr(CSR_DARKNESS_THRESHOLD, thresh_value, 1'b1);
   endtask

   function automatic req_payload_type make_pixel(input logic [CHAN_W-1:0] red,
                                                  input logic [CHAN_W-1:0] green,
                                                  input logic [CHAN_W-1:0] blue);
      req_payload_type item;
      item.cmd   = CMD_PIXEL;
      item.red   = red;
      item.green = green;
      item.blue  = blue;
      return item;
   endfunction

   // Mostly light paper with sparse dark ink, so that dilation has isolated
   // marks to grow; some fully random pixels keep every channel bit moving.
   function automatic req_payload_type random_pixel();
      int unsigned style;
      style = $urandom_range(0, 9);
      if (style < 2)
         return make_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
      if (style == 2)
         return make_pixel(CHAN_W'($urandom_range(0, 90)), CHAN_W'($urandom_range(0, 90)),
                           CHAN_W'($urandom_range(0, 90)));
      return make_pixel(CHAN_W'($urandom_range(170, 255)), CHAN_W'($urandom_range(170, 255)),
                        CHAN_W'($urandom_range(170, 255)));
   endfunction

   // The colour channels of a drain tick are ignored, so they carry noise.
   function automatic req_payload_type random_drain();
      req_payload_type item;
      item     = req_payload_type'($urandom);
      item.cmd = CMD_DRAIN;
      return item;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_width();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 3) return CSR_DATA_W'($urandom_range(0, 2));
      if (pick < 5) return CSR_DATA_W'($urandom_range(15, WIDEST_FRAME));
      return CSR_DATA_W'($urandom_range(3, 14));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_height();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 3) return CSR_DATA_W'($urandom_range(0, 2));
      if (pick < 5) return CSR_DATA_W'($urandom_range(9, 16));
      return CSR_DATA_W'($urandom_range(3, 8));
   endfunction

   // The threshold register is ten bits wide; the top data bit is written too,
   // and must be dropped by the block.
   function automatic logic [CSR_DATA_W-1:0] random_threshold();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return CSR_DATA_W'(FULL_DARKNESS);
         2: return CSR_DATA_W'(1023);
         3: return CSR_DATA_W'($urandom_range(0, 2047));
         default: return CSR_DATA_W'($urandom_range(250, 550));
      endcase
   endfunction

   // Streams one frame: pixels until the rows are complete, then drain ticks until
   // the walker wraps. In rough mode some items are deliberately of the wrong
   // kind, and now and then the size changes in the middle of the frame.
   task automatic run_frame(input bit rough);
      req_payload_type item;
      int unsigned     taken;
      bit              noise;
      taken = 0;
      do begin
         if (rough && taken > 0 && $urandom_range(0, 199) == 0) begin
            wait_for_drain();
            if ($urandom_range(0, 1) == 0) program_sizes(1'b1, random_width(), 1'b0, '0, 1'b0, '0);
            else program_sizes(1'b0, '0, 1'b1, random_height(), 1'b0, '0);
         end
         noise = rough && $urandom_range(0, 11) == 0;
         item  = (tracker.draining() ^ noise) ? random_drain() : random_pixel();
         if (!noise) taken++;
         send_item(item);
      end while (taken == 0 || !tracker.at_frame_start());
      counted_items += taken;
   endtask

   // Receiver: checks every result transfer and drives rsp_stall from a pattern of
   // its own. It switches between segments with no stall, light stall, heavy stall
   // and a toggling stall, and once holds off long enough to back the block up.
   initial begin : response_side
      int unsigned segment_left;
      int unsigned stall_mode;
      int unsigned hold_left;
      segment_left = 0;
      stall_mode   = 0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            tracker.take_mask_pixel(rsp_data);
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            hold_left       = LONG_HOLD_CYCLES;
         end
         if (segment_left == 0) begin
            segment_left = $urandom_range(10, 120);
            stall_mode   = $urandom_range(0, 3);
         end
         segment_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin : stimulus
      tracker         = new();
      burst_left      = 0;
      counted_items   = 0;
      long_hold_armed = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Smallest frame, reached through width and height values below the
      // minimum, with a zero threshold so that any darkness at all is foreground.
      program_sizes(1'b1, CSR_DATA_W'(0), 1'b1, CSR_DATA_W'(1), 1'b1, CSR_DATA_W'(0));
      send_item(make_pixel(8'd0, 8'd0, 8'd0));
      // A drain tick before the frame's last pixel must not produce anything.
      send_item(random_drain());
      send_item(make_pixel(8'd255, 8'd255, 8'd255));
      send_item(make_pixel(8'd1, 8'd2, 8'd3));
      send_item(make_pixel(8'd255, 8'd255, 8'd255));
      // The single interior pixel of a 3x3 frame.
      send_item(make_pixel(8'd0, 8'd0, 8'd0));
      // Darkness of one, just above the zero threshold.
      send_item(make_pixel(8'd255, 8'd255, 8'd254));
      send_item(make_pixel(8'd128, 8'd64, 8'd32));
      send_item(make_pixel(8'd255, 8'd255, 8'd255));
      send_item(make_pixel(8'd0, 8'd0, 8'd0));
      // Rows are now pending, so this pixel is ignored.
      send_item(make_pixel(8'd0, 8'd0, 8'd0));
      repeat (PASSES * 3) send_item(random_drain());
      // Nothing is pending any more, so this tick gives no result.
      send_item(random_drain());
      wait_for_drain();

      // The widest frame the random settings ever reach. A height of four fills
      // every row slot of every stage at every column they use, so later size
      // changes mid-frame only ever read line entries that hold data.
      program_sizes(1'b1, CSR_DATA_W'(WIDEST_FRAME), 1'b1, CSR_DATA_W'(4),
                    1'b1, CSR_DATA_W'($urandom_range(300, 460)));
      run_frame(1'b0);
      wait_for_drain();

      // A tall frame on the narrowest width.
      program_sizes(1'b1, CSR_DATA_W'(1), 1'b1, CSR_DATA_W'(TALL_FRAME),
                    1'b1, CSR_DATA_W'($urandom_range(300, 460)));
      run_frame(1'b0);
      wait_for_drain();

      // Random frames with random settings. The receiver's long hold-off starts
      // right away while the sender keeps offering pixels.
      counted_items   = 0;
      long_hold_armed = 1'b1;
      while (counted_items < RANDOM_ITEMS) begin
         program_sizes($urandom_range(0, 2) != 0, random_width(),
                       $urandom_range(0, 2) != 0, random_height(),
                       $urandom_range(0, 2) != 0, random_threshold());
         run_frame(1'b1);
         wait_for_drain();
      end

      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      tracker.count_leftovers();
      if (tracker.error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // Far beyond the slowest correct run, including the long hold-off.
   initial begin : watchdog
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/btd_pkg.sv
design/binary_threshold_dilate_core.sv
design/btd_checker.sv
verif/binary_threshold_dilate_core_tb.sv
